// ===== hdl/assert_macros.svh =====
// Assertion helpers for the allocator RTL. They use the clk and rst of the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define NFHA_ASSERT_ALWAYS(label, expr, msg) label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define NFHA_ASSERT_NEXT(label, ante, cons, msg) label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/nfha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nfha_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_BAD_FREE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_INS,
    S_A_APPEND,
    S_SH_RD,
    S_SH_WR,
    S_F_RD,
    S_F_CHK,
    S_F_NX,
    S_F_NXC,
    S_F_PV,
    S_F_PVC,
    S_F_SELF,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] bytes;
    logic        taken;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/nfha_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nfha_table (
  input  wire                                clk,
  input  wire                                we,
  input  wire  [nfha_pkg::IDX_W-1:0]         waddr,
  input  wire  nfha_pkg::entry_t             wdata,
  input  wire  [nfha_pkg::IDX_W-1:0]         raddr,
  output nfha_pkg::entry_t                   rdata
);
  import nfha_pkg::*;

  entry_t mem [0:MAX_BLOCKS-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/next_fit_heap_allocator.sv =====
// Next-fit heap allocator with coalescing over a 64 KiB arena and a 64-entry block table.
// Requests arrive on req_valid/req_ready with mode, request_size and user_address; each
// request yields exactly one response on rsp_valid/rsp_ready with granted_address and status.
// The block takes one request at a time: req_ready is high only while the sequencer is idle.
// The table memory has a registered read port, so every read needs a read state of its own.
// An allocation reads and checks entries circularly from the cursor and, on a split,
// shifts the table tail up by one, a read and a write per entry; a miss appends at the break.
// A free scans from entry zero for the address, then may merge each neighbour, each merge
// shifting the tail down by one, a read and a write per entry.
// The response is held in an output register; a new request is accepted while it waits,
// but a finished request waits in its last state until the output register is free.
// A synchronous, active-high reset empties the table, clears the cursor and the break,
// and drops any pending response. No clearing pass over the memory is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module next_fit_heap_allocator (
  input  wire         clk,
  input  wire         rst,
  input  wire         req_valid,
  output logic        req_ready,
  input  wire         mode,
  input  wire  [15:0] request_size,
  input  wire  [15:0] user_address,
  output logic        rsp_valid,
  input  wire         rsp_ready,
  output logic [15:0] granted_address,
  output logic [1:0]  status
);
  import nfha_pkg::*;

  localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);

  state_t st, st_next, ret, ret_next;
  logic [CNT_W-1:0] total, total_next, cnt, cnt_next, sh_left, sh_left_next;
  logic [IDX_W-1:0] cursor, cursor_next, idx, idx_next;
  logic [IDX_W-1:0] sh_src, sh_src_next, sh_dst, sh_dst_next;
  logic             sh_up, sh_up_next;
  logic [16:0]      brk, brk_next;
  logic             mode_r, mode_r_next;
  logic [15:0]      size_r, size_r_next, uaddr_r, uaddr_r_next;
  logic [15:0]      w_start, w_start_next, w_bytes, w_bytes_next;
  logic [15:0]      res_addr, res_addr_next;
  status_t          res_status, res_status_next;
  logic             rsp_valid_next, load;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, q;

  logic [CNT_W-1:0] idx_p1, up_cnt, drop_next_cnt, drop_self_cnt;
  logic [15:0]      spare;
  logic             fit, can_split, hit, app_full, app_over;

  nfha_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  assign idx_p1        = {1'b0, idx} + CNT_W'(1);
  assign up_cnt        = total - idx_p1;
  assign drop_next_cnt = total - idx_p1 - CNT_W'(1);
  assign drop_self_cnt = total - idx_p1;
  assign spare         = q.bytes - size_r;
  assign fit           = !q.taken && (q.bytes >= size_r);
  assign can_split     = (spare >= HDR16) && (total < CNT_W'(MAX_BLOCKS));
  assign hit           = ({1'b0, q.start} + 17'(HEADER_BYTES)) == {1'b0, uaddr_r};
  assign app_full      = total >= CNT_W'(MAX_BLOCKS);
  assign app_over      = ({1'b0, brk} + 18'(HEADER_BYTES) + 18'(size_r)) > 18'(ARENA_BYTES);
  assign load          = (st == S_DONE) && (!rsp_valid || rsp_ready);
  assign req_ready     = (st == S_IDLE);

  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: begin
        if (req_valid) begin
          if (mode == MODE_ALLOC) begin
            st_next = (total == '0) ? S_A_APPEND : S_A_RD;
          end else begin
            st_next = (total == '0) ? S_DONE : S_F_RD;
          end
        end
      end
      S_A_RD:     st_next = S_A_CHK;
      S_A_CHK: begin
        if (fit) begin
          if (can_split) begin
            st_next = (up_cnt != '0) ? S_SH_RD : S_A_INS;
          end else begin
            st_next = S_DONE;
          end
        end else begin
          st_next = (cnt + CNT_W'(1) == total) ? S_A_APPEND : S_A_RD;
        end
      end
      S_A_INS:    st_next = S_DONE;
      S_A_APPEND: st_next = S_DONE;
      S_SH_RD:    st_next = S_SH_WR;
      S_SH_WR:    st_next = (sh_left == CNT_W'(1)) ? ret : S_SH_RD;
      S_F_RD:     st_next = S_F_CHK;
      S_F_CHK: begin
        if (hit) begin
          if (!q.taken) begin
            st_next = S_DONE;
          end else begin
            st_next = (idx_p1 < total) ? S_F_NX : S_F_PV;
          end
        end else begin
          st_next = (idx_p1 == total) ? S_DONE : S_F_RD;
        end
      end
      S_F_NX:     st_next = S_F_NXC;
      S_F_NXC:    st_next = (!q.taken && drop_next_cnt != '0) ? S_SH_RD : S_F_PV;
      S_F_PV:     st_next = (idx == '0) ? S_F_SELF : S_F_PVC;
      S_F_PVC:    st_next = (!q.taken && drop_self_cnt != '0) ? S_SH_RD : S_F_SELF;
      S_F_SELF:   st_next = S_DONE;
      S_DONE:     st_next = load ? S_IDLE : S_DONE;
      default:    st_next = S_IDLE;
    endcase
  end

  always_comb begin
    total_next      = total;
    cnt_next        = cnt;
    cursor_next     = cursor;
    idx_next        = idx;
    sh_src_next     = sh_src;
    sh_dst_next     = sh_dst;
    sh_left_next    = sh_left;
    sh_up_next      = sh_up;
    ret_next        = ret;
    brk_next        = brk;
    mode_r_next     = mode_r;
    size_r_next     = size_r;
    uaddr_r_next    = uaddr_r;
    w_start_next    = w_start;
    w_bytes_next    = w_bytes;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    we              = 1'b0;
    raddr           = idx;
    waddr           = idx;
    wdata           = '{start: w_start, bytes: w_bytes, taken: 1'b0};
    unique case (st)
      S_IDLE: begin
        if (req_valid) begin
          mode_r_next     = mode;
          size_r_next     = request_size;
          uaddr_r_next    = user_address;
          cnt_next        = '0;
          res_addr_next   = '0;
          res_status_next = ST_OK;
          if (mode == MODE_ALLOC) begin
            if ({1'b0, cursor} >= total) begin
              cursor_next = '0;
              idx_next    = '0;
            end else begin
              idx_next = cursor;
            end
          end else begin
            idx_next = '0;
            if (total == '0) begin
              res_status_next = ST_BAD_FREE;
            end
          end
        end
      end
      S_A_RD: raddr = idx;
      S_A_CHK: begin
        if (fit) begin
          cursor_next   = idx;
          res_addr_next = q.start + HDR16;
          we            = 1'b1;
          waddr         = idx;
          wdata         = '{start: q.start, bytes: can_split ? size_r : q.bytes, taken: 1'b1};
          if (can_split) begin
            w_start_next = q.start + HDR16 + size_r;
            w_bytes_next = spare - HDR16;
            sh_src_next  = IDX_W'(total - CNT_W'(1));
            sh_dst_next  = IDX_W'(total);
            sh_left_next = up_cnt;
            sh_up_next   = 1'b1;
            ret_next     = S_A_INS;
          end
        end else begin
          cnt_next = cnt + CNT_W'(1);
          idx_next = (idx_p1 == total) ? '0 : IDX_W'(idx_p1);
        end
      end
      S_A_INS: begin
        we         = 1'b1;
        waddr      = IDX_W'(idx_p1);
        wdata      = '{start: w_start, bytes: w_bytes, taken: 1'b0};
        total_next = total + CNT_W'(1);
      end
      S_A_APPEND: begin
        if (app_full) begin
          res_status_next = ST_TABLE_FULL;
        end else if (app_over) begin
          res_status_next = ST_EXHAUSTED;
        end else begin
          we            = 1'b1;
          waddr         = IDX_W'(total);
          wdata         = '{start: brk[15:0], bytes: size_r, taken: 1'b1};
          cursor_next   = IDX_W'(total);
          total_next    = total + CNT_W'(1);
          brk_next      = brk + 17'(HEADER_BYTES) + 17'(size_r);
          res_addr_next = brk[15:0] + HDR16;
        end
      end
      S_SH_RD: raddr = sh_src;
      S_SH_WR: begin
        we           = 1'b1;
        waddr        = sh_dst;
        wdata        = q;
        sh_left_next = sh_left - CNT_W'(1);
        if (sh_up) begin
          sh_src_next = sh_src - IDX_W'(1);
          sh_dst_next = sh_dst - IDX_W'(1);
        end else begin
          sh_src_next = sh_src + IDX_W'(1);
          sh_dst_next = sh_dst + IDX_W'(1);
        end
      end
      S_F_RD: raddr = idx;
      S_F_CHK: begin
        if (hit) begin
          if (!q.taken) begin
            res_status_next = ST_BAD_FREE;
          end else begin
            w_start_next = q.start;
            w_bytes_next = q.bytes;
          end
        end else begin
          idx_next = IDX_W'(idx_p1);
          if (idx_p1 == total) begin
            res_status_next = ST_BAD_FREE;
          end
        end
      end
      S_F_NX: raddr = IDX_W'(idx_p1);
      S_F_NXC: begin
        if (!q.taken) begin
          w_bytes_next = w_bytes + HDR16 + q.bytes;
          total_next   = total - CNT_W'(1);
          if ({1'b0, cursor} == idx_p1) begin
            cursor_next = idx;
          end else if ({1'b0, cursor} > idx_p1) begin
            cursor_next = cursor - IDX_W'(1);
          end
          sh_src_next  = idx + IDX_W'(2);
          sh_dst_next  = IDX_W'(idx_p1);
          sh_left_next = drop_next_cnt;
          sh_up_next   = 1'b0;
          ret_next     = S_F_PV;
        end
      end
      S_F_PV: raddr = idx - IDX_W'(1);
      S_F_PVC: begin
        if (!q.taken) begin
          w_start_next = q.start;
          w_bytes_next = q.bytes + HDR16 + w_bytes;
          total_next   = total - CNT_W'(1);
          if (cursor == idx) begin
            cursor_next = idx - IDX_W'(1);
          end else if (cursor > idx) begin
            cursor_next = cursor - IDX_W'(1);
          end
          idx_next     = idx - IDX_W'(1);
          sh_src_next  = IDX_W'(idx_p1);
          sh_dst_next  = idx;
          sh_left_next = drop_self_cnt;
          sh_up_next   = 1'b0;
          ret_next     = S_F_SELF;
        end
      end
      S_F_SELF: begin
        we    = 1'b1;
        waddr = idx;
        wdata = '{start: w_start, bytes: w_bytes, taken: 1'b0};
        if (idx_p1 == total) begin
          brk_next = {1'b0, w_start};
          if (idx == '0) begin
            total_next  = '0;
            cursor_next = '0;
          end else begin
            total_next = total - CNT_W'(1);
            if (cursor == idx) begin
              cursor_next = idx - IDX_W'(1);
            end else if (cursor > idx) begin
              cursor_next = cursor - IDX_W'(1);
            end
          end
        end
      end
      S_DONE: raddr = idx;
      default: raddr = idx;
    endcase
  end

  assign rsp_valid_next = load || (rsp_valid && !rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      ret       <= S_IDLE;
      total     <= '0;
      cursor    <= '0;
      brk       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      st        <= st_next;
      ret       <= ret_next;
      total     <= total_next;
      cursor    <= cursor_next;
      brk       <= brk_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    idx        <= idx_next;
    sh_src     <= sh_src_next;
    sh_dst     <= sh_dst_next;
    sh_left    <= sh_left_next;
    sh_up      <= sh_up_next;
    mode_r     <= mode_r_next;
    size_r     <= size_r_next;
    uaddr_r    <= uaddr_r_next;
    w_start    <= w_start_next;
    w_bytes    <= w_bytes_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
    if (load) begin
      granted_address <= (mode_r == MODE_FREE) ? 16'd0 : res_addr;
      status          <= res_status;
    end
  end

  `NFHA_ASSERT_ALWAYS(a_total_bound, total <= CNT_W'(MAX_BLOCKS), "block count beyond table")
  `NFHA_ASSERT_ALWAYS(a_empty_break, total != '0 || brk == '0, "empty table with nonzero break")
  `NFHA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, st != S_IDLE, "request not taken up")
  `NFHA_ASSERT_ALWAYS(a_fail_zero, !rsp_valid || status == ST_OK || granted_address == '0, "failure with address")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import nfha_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        mode = MODE_ALLOC;
  logic [15:0] request_size = '0;
  logic [15:0] user_address = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [15:0] granted_address;
  logic [1:0]  status;

  next_fit_heap_allocator u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .mode(mode),
    .request_size(request_size),
    .user_address(user_address),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .granted_address(granted_address),
    .status(status)
  );

  always #4 clk = ~clk;

  typedef struct {
    logic [15:0] addr;
    status_t     st;
  } grant_t;

  typedef struct {
    logic        op;
    logic [15:0] size;
    logic [15:0] uaddr;
    bit          typed;
    logic [15:0] exp_addr;
    status_t     exp_st;
  } row_t;

  grant_t      pending_grants[$];
  logic [15:0] live_addrs[$];
  logic [15:0] last_freed;
  int          blk_start[MAX_BLOCKS];
  int          blk_bytes[MAX_BLOCKS];
  bit          blk_taken[MAX_BLOCKS];
  int          blk_count;
  int          fit_cursor;
  int          heap_break;
  int          fails;
  int          cycles;
  int          send_idle;
  int          recv_idle;
  bit          hold_request;
  int          hold_left;

  function automatic void remove_entry(int idx);
    if (idx >= blk_count) return;
    for (int k = idx; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k + 1];
      blk_bytes[k] = blk_bytes[k + 1];
      blk_taken[k] = blk_taken[k + 1];
    end
    blk_count--;
    if (fit_cursor == idx) begin
      fit_cursor = (idx > 0) ? idx - 1 : 0;
    end else if (fit_cursor > idx) begin
      fit_cursor--;
    end
  endfunction

  function automatic void add_free_entry(int idx, int start, int bytes);
    for (int k = blk_count; k > idx; k--) begin
      blk_start[k] = blk_start[k - 1];
      blk_bytes[k] = blk_bytes[k - 1];
      blk_taken[k] = blk_taken[k - 1];
    end
    blk_start[idx] = start;
    blk_bytes[idx] = bytes;
    blk_taken[idx] = 1'b0;
    blk_count++;
    if (fit_cursor >= idx) fit_cursor++;
  endfunction

  function automatic grant_t predict_grant(logic op, logic [15:0] size, logic [15:0] uaddr);
    grant_t g;
    int     a;
    int     i;
    int     spare;
    bit     found;
    g.addr = '0;
    g.st = ST_OK;
    a = 0;
    found = 1'b0;
    if (op == MODE_ALLOC) begin
      if (blk_count > 0) begin
        if (fit_cursor >= blk_count) fit_cursor = 0;
        for (int k = 0; k < blk_count && !found; k++) begin
          i = (fit_cursor + k) % blk_count;
          if (!blk_taken[i] && blk_bytes[i] >= size) begin
            spare = blk_bytes[i] - size;
            if (spare >= HEADER_BYTES && blk_count < MAX_BLOCKS) begin
              blk_bytes[i] = size;
              add_free_entry(i + 1, blk_start[i] + HEADER_BYTES + size, spare - HEADER_BYTES);
            end
            blk_taken[i] = 1'b1;
            fit_cursor = i;
            a = blk_start[i] + HEADER_BYTES;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        if (blk_count >= MAX_BLOCKS) begin
          g.st = ST_TABLE_FULL;
        end else if (heap_break + HEADER_BYTES + size > ARENA_BYTES) begin
          g.st = ST_EXHAUSTED;
        end else begin
          i = blk_count;
          blk_start[i] = heap_break;
          blk_bytes[i] = size;
          blk_taken[i] = 1'b1;
          blk_count++;
          fit_cursor = i;
          heap_break = heap_break + HEADER_BYTES + size;
          a = blk_start[i] + HEADER_BYTES;
        end
      end
      if (g.st == ST_OK) begin
        g.addr = a[15:0];
        if (a < 65536) live_addrs.push_back(a[15:0]);
      end
    end else begin
      i = -1;
      for (int k = 0; k < blk_count && i < 0; k++) begin
        if (blk_start[k] + HEADER_BYTES == uaddr) i = k;
      end
      if (i < 0 || !blk_taken[i]) begin
        g.st = ST_BAD_FREE;
      end else begin
        blk_taken[i] = 1'b0;
        if (i + 1 < blk_count && !blk_taken[i + 1]) begin
          blk_bytes[i] = blk_bytes[i] + HEADER_BYTES + blk_bytes[i + 1];
          remove_entry(i + 1);
        end
        if (i > 0 && !blk_taken[i - 1]) begin
          blk_bytes[i - 1] = blk_bytes[i - 1] + HEADER_BYTES + blk_bytes[i];
          remove_entry(i);
          i--;
        end
        if (i + 1 == blk_count) begin
          heap_break = blk_start[i];
          if (i == 0) begin
            blk_count = 0;
            fit_cursor = 0;
          end else begin
            remove_entry(i);
          end
        end
        for (int k = 0; k < live_addrs.size(); k++) begin
          if (live_addrs[k] == uaddr) begin
            live_addrs.delete(k);
            break;
          end
        end
        last_freed = uaddr;
      end
    end
    return g;
  endfunction

  task automatic send_request(row_t r);
    grant_t g;
    int     gap;
    gap = 0;
    while (send_idle > 0 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= r.op;
    request_size <= r.size;
    user_address <= r.uaddr;
    do @(posedge clk); while (!req_ready);
    g = predict_grant(r.op, r.size, r.uaddr);
    if (r.typed) begin
      g.addr = r.exp_addr;
      g.st = r.exp_st;
    end
    pending_grants.push_back(g);
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(64));
    if (r < 90) return 16'($urandom_range(1024));
    if (r < 97) return 16'($urandom_range(8192));
    return 16'($urandom);
  endfunction

  function automatic row_t random_row(bit fill);
    row_t r;
    int   p;
    r.typed = 1'b0;
    r.exp_addr = '0;
    r.exp_st = ST_OK;
    r.op = MODE_ALLOC;
    r.size = fill ? 16'($urandom_range(15)) : pick_size();
    r.uaddr = 16'($urandom);
    p = $urandom_range(99);
    if (!fill && p >= 45) begin
      r.op = MODE_FREE;
      r.size = 16'($urandom);
      if (p < 85 && live_addrs.size() > 0) begin
        r.uaddr = live_addrs[$urandom_range(live_addrs.size() - 1)];
      end else if (p >= 92) begin
        r.uaddr = last_freed;
      end else if (p < 85) begin
        r.op = MODE_ALLOC;
        r.size = pick_size();
      end
    end
    return r;
  endfunction

  row_t directed[] = '{
    '{MODE_ALLOC, 16'd0,     16'd0,     1'b1, 16'd24, ST_OK},
    '{MODE_FREE,  16'd0,     16'd24,    1'b1, 16'd0,  ST_OK},
    '{MODE_FREE,  16'd0,     16'd24,    1'b1, 16'd0,  ST_BAD_FREE},
    '{MODE_FREE,  16'hffff,  16'd0,     1'b1, 16'd0,  ST_BAD_FREE},
    '{MODE_ALLOC, 16'hffff,  16'hffff,  1'b1, 16'd0,  ST_EXHAUSTED},
    '{MODE_ALLOC, 16'd65512, 16'd0,     1'b1, 16'd24, ST_OK},
    '{MODE_ALLOC, 16'd0,     16'd0,     1'b1, 16'd0,  ST_EXHAUSTED},
    '{MODE_FREE,  16'd0,     16'hffff,  1'b1, 16'd0,  ST_BAD_FREE},
    '{MODE_FREE,  16'd0,     16'd24,    1'b1, 16'd0,  ST_OK},
    '{MODE_ALLOC, 16'd100,   16'd0,     1'b1, 16'd24, ST_OK},
    '{MODE_ALLOC, 16'd50,    16'd0,     1'b1, 16'd148, ST_OK},
    '{MODE_ALLOC, 16'd10,    16'd0,     1'b1, 16'd222, ST_OK},
    '{MODE_FREE,  16'd0,     16'd148,   1'b1, 16'd0,  ST_OK},
    '{MODE_ALLOC, 16'd10,    16'd0,     1'b0, 16'd0,  ST_OK},
    '{MODE_ALLOC, 16'd0,     16'd0,     1'b0, 16'd0,  ST_OK},
    '{MODE_FREE,  16'd0,     16'd160,   1'b0, 16'd0,  ST_OK},
    '{MODE_FREE,  16'd0,     16'd24,    1'b0, 16'd0,  ST_OK},
    '{MODE_FREE,  16'd0,     16'd222,   1'b0, 16'd0,  ST_OK},
    '{MODE_FREE,  16'd0,     16'd148,   1'b0, 16'd0,  ST_OK},
    '{MODE_ALLOC, 16'd65488, 16'd0,     1'b0, 16'd0,  ST_OK},
    '{MODE_ALLOC, 16'd0,     16'd0,     1'b0, 16'd0,  ST_OK},
    '{MODE_FREE,  16'd0,     16'd0,     1'b0, 16'd0,  ST_OK},
    '{MODE_FREE,  16'd0,     16'd24,    1'b0, 16'd0,  ST_OK}
  };

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected response: granted_address %0d status %0d", granted_address, status);
        fails++;
      end else begin
        g = pending_grants.pop_front();
        if (granted_address !== g.addr) begin
          $error("granted_address: expected %0d, actual %0d", g.addr, granted_address);
          fails++;
        end
        if (status !== g.st) begin
          $error("status: expected %0d, actual %0d", g.st, status);
          fails++;
        end
      end
    end
    if (hold_request && hold_left == 0) begin
      hold_request <= 1'b0;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= (hold_left == 1);
    end else begin
      rsp_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  initial begin
    int   fill_left;
    row_t r;
    fails = 0;
    cycles = 0;
    blk_count = 0;
    fit_cursor = 0;
    heap_break = 0;
    last_freed = '0;
    hold_request = 1'b0;
    hold_left = 0;
    send_idle = 35;
    recv_idle = 71;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[n]) send_request(directed[n]);
    fill_left = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 35 : (phase == 1) ? 71 : 0;
      recv_idle = (phase == 0) ? 71 : (phase == 1) ? 35 : 0;
      for (int n = 0; n < 560; n++) begin
        if (n % 200 == 20) fill_left = 80;
        if (phase == 2 && n == 300) hold_request = 1'b1;
        r = random_row(fill_left > 0);
        if (fill_left > 0) fill_left--;
        send_request(r);
      end
    end
    req_valid <= 1'b0;
    while (pending_grants.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
